FILE: rtl/prefix_code_decoder_macros.svh
// Assertion macros used by the prefix-code decoder RTL.
`ifndef PREFIX_CODE_DECODER_MACROS_SVH
`define PREFIX_CODE_DECODER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define PCD_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define PCD_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) else $error(msg);

`endif

FILE: rtl/pcd_pkg.sv
// Constants, types and the match function of the prefix-code decoder.
`default_nettype none
package pcd_pkg;

  localparam int ENTRIES      = 64;
  localparam int MAX_CODE_LEN = 16;
  localparam int IDX_W        = $clog2(ENTRIES);
  localparam int CNT_W        = $clog2(MAX_CODE_LEN + 1);
  localparam int WORD_W       = 16;
  localparam int LEN_W        = 5;
  localparam int BLK_W        = 6;
  localparam int ENTRY_W      = WORD_W + LEN_W;
  localparam int IN_TDATA_W   = 32;
  localparam int OUT_TDATA_W  = 8;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_BIT  = 1'b1;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [LEN_W-1:0]  len;
  } entry_t;

  // True when a stored entry equals the accumulated code exactly.
  function automatic logic entry_hit(entry_t e, logic [MAX_CODE_LEN-1:0] bits,
                                     logic [CNT_W-1:0] cnt);
    logic [31:0] mask;
    logic [31:0] w;
    logic [31:0] p;
    mask = (32'd1 << e.len) - 32'd1;
    w    = 32'(e.word) & mask;
    p    = 32'(bits);
    return (e.len != '0) && (32'(e.len) == 32'(cnt)) && (w == p);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/prefix_code_decoder.sv
// Top level of the prefix-code decoder: table RAM, bit accumulator and search sequencer.
//
// The block decodes a prefix-coded bit stream against a loadable codeword table.
// Input beats arrive on the s_ group. s_tuser selects the kind of beat: a load
// beat writes one table entry (block number, codeword bits, codeword length) and
// gives no result. A code-bit beat appends one bit to the accumulator and then
// walks the table RAM one entry per cycle, comparing each stored codeword with the
// accumulator through one shared comparator. The first (lowest) matching entry ends
// the walk early and its block number goes out on the m_ group; after MAX_CODE_LEN
// bits with no match a beat flagged by m_tuser goes out. The table walk reads
// through the single registered RAM read port; with no match it reads every entry.
// The result register parts the two sides: a new input beat is taken while an
// earlier result still waits for m_tready, and a walk that ends while the result
// register is full waits until it drains.
// Reset clears the accumulator, the output valid and the per-entry valid bits, so
// every table entry reads as empty right after reset; no clearing pass is needed.
`include "prefix_code_decoder_macros.svh"
`default_nettype none
module prefix_code_decoder (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // entry_block [5:0], entry_bits [21:6], entry_length [26:22], code_bit [27], zero [31:28]
  input  wire logic [pcd_pkg::IN_TDATA_W-1:0] s_tdata,
  // opcode [0]
  input  wire logic                           s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // block_out [5:0], zero [7:6]
  output logic [pcd_pkg::OUT_TDATA_W-1:0]     m_tdata,
  // bad_code [0]
  output logic                                m_tuser
);
  import pcd_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]              state;
  logic [ENTRIES-1:0]      valid;
  logic [MAX_CODE_LEN-1:0] pend_bits;
  logic [CNT_W-1:0]        pend_cnt;
  logic [IDX_W:0]          issue_idx;
  logic                    cmp_vld;
  logic [IDX_W-1:0]        cmp_idx;
  logic                    vbit;
  logic [BLK_W-1:0]        res_block;
  logic                    res_bad;
  logic [BLK_W-1:0]        out_block;

  // Unpacked input beat.
  logic              in_op;
  logic [BLK_W-1:0]  in_blk;
  logic [WORD_W-1:0] in_bits;
  logic [LEN_W-1:0]  in_len;
  logic              in_cbit;

  logic   accept;
  logic   in_range;
  logic   load_en;
  logic   issue_on;
  logic   hit;
  logic   last;
  logic   out_free;
  entry_t wr_entry;
  entry_t rd_entry;

  assign in_op   = s_tuser;
  assign in_blk  = s_tdata[BLK_W-1:0];
  assign in_bits = s_tdata[BLK_W+WORD_W-1:BLK_W];
  assign in_len  = s_tdata[BLK_W+WORD_W+LEN_W-1:BLK_W+WORD_W];
  assign in_cbit = s_tdata[BLK_W+WORD_W+LEN_W];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign in_range = (32'(in_blk) < ENTRIES);
  assign load_en  = accept && (in_op == OP_LOAD) && in_range;
  assign wr_entry = '{word: in_bits, len: in_len};

  // The walk issues one RAM read per cycle; the compare happens in the cycle after the read.
  assign issue_on = (state == ST_SCAN) && (issue_idx < (IDX_W+1)'(ENTRIES));

  pcd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (load_en),
    .wr_addr (IDX_W'(in_blk)),
    .wr_data (wr_entry),
    .rd_en   (issue_on),
    .rd_addr (issue_idx[IDX_W-1:0]),
    .rd_data (rd_entry)
  );

  // An entry never loaded since reset counts as empty through its valid bit.
  assign hit      = (state == ST_SCAN) && cmp_vld && vbit &&
                    entry_hit(rd_entry, pend_bits, pend_cnt);
  assign last     = (state == ST_SCAN) && cmp_vld && (cmp_idx == IDX_W'(ENTRIES - 1));
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      valid     <= '0;
      pend_bits <= '0;
      pend_cnt  <= '0;
      issue_idx <= '0;
      cmp_vld   <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      cmp_vld <= issue_on;
      if (issue_on) begin
        issue_idx <= issue_idx + 1'b1;
      end

      if (load_en) begin
        valid[IDX_W'(in_blk)] <= 1'b1;
      end

      case (state)
        ST_IDLE: begin
          if (accept && (in_op == OP_BIT)) begin
            pend_bits <= {pend_bits[MAX_CODE_LEN-2:0], in_cbit};
            pend_cnt  <= pend_cnt + 1'b1;
            issue_idx <= '0;
            state     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (hit) begin
            res_block <= BLK_W'(cmp_idx);
            res_bad   <= 1'b0;
            pend_bits <= '0;
            pend_cnt  <= '0;
            state     <= ST_HOLD;
          end else if (last) begin
            if (32'(pend_cnt) >= MAX_CODE_LEN) begin
              res_block <= '0;
              res_bad   <= 1'b1;
              pend_bits <= '0;
              pend_cnt  <= '0;
              state     <= ST_HOLD;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      // Result register: loads from the held result, otherwise drains on m_tready.
      if ((state == ST_HOLD) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Compare stage payload: index and valid bit travel with the RAM read.
  always_ff @(posedge clk) begin
    if (issue_on) begin
      cmp_idx <= issue_idx[IDX_W-1:0];
      vbit    <= valid[issue_idx[IDX_W-1:0]];
    end
    if ((state == ST_HOLD) && out_free) begin
      out_block <= res_block;
      m_tuser   <= res_bad;
    end
  end

  assign m_tdata = {{(OUT_TDATA_W - BLK_W){1'b0}}, out_block};

  `PCD_ASSERT_NOW(a_bad_zero_block, m_tvalid && m_tuser, out_block == '0, "bad code with nonzero block")
  `PCD_ASSERT_NOW(a_cnt_limit, 1'b1, 32'(pend_cnt) <= MAX_CODE_LEN, "accumulator count overflow")
  `PCD_ASSERT_NEXT(a_bit_starts_walk, accept && (in_op == OP_BIT), state == ST_SCAN, "bit beat did not start the table walk")
  `PCD_ASSERT_NEXT(a_hold_waits, (state == ST_HOLD) && m_tvalid && !m_tready, (state == ST_HOLD) && m_tvalid, "held result lost while output stalled")

endmodule
`default_nettype wire

FILE: rtl/pcd_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none
module pcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire
